>>> sv/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants for the LED matrix row scanner: register
// indexes, field widths, item kinds, chain codes and scanner states.
// ----------------------------------------------------------------------------
package lmrs_pkg;

  // fixed field widths
  localparam int CFG_COLS_W = 5;
  localparam int CFG_ROWS_W = 4;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int PIX_W      = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

  // reset values of the configuration registers
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 5'd16;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 4'd8;

  // item kinds
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // shift chain select
  localparam logic CHAIN_COL = 1'b0;
  localparam logic CHAIN_ROW = 1'b1;

  // scanner states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ZERO,
    S_TOKEN,
    S_PIX
  } scan_state_t;

endpackage

>>> sv/lmrs_frame.sv
// ----------------------------------------------------------------------------
// lmrs_frame
// Monochrome frame store in flip-flops: one word of column bits per row,
// single-pixel set or clear, one whole row read at a time.
// ----------------------------------------------------------------------------
module lmrs_frame
  import lmrs_pkg::*;
#(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 8
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            wr_en,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]       wr_row,
  input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] wr_col,
  input  logic                                            wr_on,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]       rd_row,
  output logic [MAX_COLUMNS-1:0]                          rd_bits
);

  logic [MAX_COLUMNS-1:0] store_r [MAX_ROWS];

  // pixel write, cleared to all dark at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        store_r[r] <= '0;
      end
    end else if (wr_en) begin
      store_r[wr_row][wr_col] <= wr_on;
    end
  end

  // row read
  assign rd_bits = store_r[rd_row];

endmodule

>>> sv/led_matrix_row_scanner_core.sv
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_core
// Frame store plus multiplexed row scanner feeding a column and a row chain.
// ----------------------------------------------------------------------------
// A write item gives no result; writes outside the wired columns or rows
// are dropped. An advance item steps the row counter and then streams
// 2*C+1 result items, C being the wired column count (33 at sixteen
// columns): C blanking zeros to the column chain, the row token to the row
// chain, then the new row's pixels from column zero. Results leave one per
// cycle through the output register while out_ready holds; a new item is
// taken once the last bit is generated, while that bit may still wait in
// the output register.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_core
  import lmrs_pkg::*;
#(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [PIX_W-1:0]      in_pixel_x,
  input  logic [PIX_W-1:0]      in_pixel_y,
  input  logic                  in_pixel_on,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_chain,
  output logic                  out_bit_out,
  output logic                  out_latch_after,
  output logic                  out_last
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNTW  = $clog2(MAX_COLUMNS + 1);
  localparam int ROWSW = $clog2(MAX_ROWS + 1);

  // configuration registers
  logic [CFG_COLS_W-1:0] cols_cfg_r;
  logic [CFG_ROWS_W-1:0] rows_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= COLS_RESET;
      rows_cfg_r <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS: cols_cfg_r <= cfg_data;
        REG_ROWS:    rows_cfg_r <= cfg_data[CFG_ROWS_W-1:0];
        default:     ;
      endcase
    end
  end

  // effective geometry
  logic [CNTW-1:0]  eff_cols;
  logic [ROWSW-1:0] eff_rows;

  always_comb begin
    if (int'(cols_cfg_r) > MAX_COLUMNS) begin
      eff_cols = CNTW'(MAX_COLUMNS);
    end else begin
      eff_cols = CNTW'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      eff_rows = ROWSW'(1);
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      eff_rows = ROWSW'(MAX_ROWS);
    end else begin
      eff_rows = ROWSW'(rows_cfg_r);
    end
  end

  // handshake decode
  scan_state_t state_r, state_nxt;
  logic        in_fire;
  logic        adv_fire;
  logic        wr_fire;
  logic        gen_go;
  logic        out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign adv_fire = in_fire && (in_kind == KIND_ADVANCE);
  assign gen_go   = (state_r != S_IDLE) && (!out_valid_r || out_ready);

  // pixel write range check
  assign wr_fire = in_fire && (in_kind == KIND_WRITE)
                   && (in_pixel_x < PIX_W'(eff_cols))
                   && (in_pixel_y < PIX_W'(eff_rows));

  // row counter step with wrap
  logic [RW-1:0]    scan_row_r;
  logic [ROWSW-1:0] row_inc;
  logic [RW-1:0]    next_row;

  assign row_inc  = ROWSW'(scan_row_r) + ROWSW'(1);
  assign next_row = (row_inc >= eff_rows) ? '0 : RW'(row_inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r <= '0;
    end else if (adv_fire) begin
      scan_row_r <= next_row;
    end
  end

  // frame store
  logic [MAX_COLUMNS-1:0] rd_bits;

  lmrs_frame #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_fire),
    .wr_row  (RW'(in_pixel_y)),
    .wr_col  (CW'(in_pixel_x)),
    .wr_on   (in_pixel_on),
    .rd_row  (next_row),
    .rd_bits (rd_bits)
  );

  // row shift register and bit counter
  logic [MAX_COLUMNS-1:0] row_sh_r;
  logic [CNTW-1:0]        cnt_r;
  logic                   col_end;
  logic                   row_zero_r;

  assign col_end = (cnt_r == CNTW'(eff_cols - CNTW'(1)));

  always_ff @(posedge clk) begin
    if (adv_fire) begin
      row_sh_r   <= rd_bits;
      row_zero_r <= (next_row == '0);
    end else if (gen_go && (state_r == S_PIX)) begin
      row_sh_r   <= row_sh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv_fire) begin
      cnt_r <= '0;
    end else if (gen_go) begin
      if (state_r == S_TOKEN || col_end) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + CNTW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (adv_fire) begin
          state_nxt = (eff_cols == '0) ? S_TOKEN : S_ZERO;
        end
      end
      S_ZERO: begin
        if (gen_go && col_end) begin
          state_nxt = S_TOKEN;
        end
      end
      S_TOKEN: begin
        if (gen_go) begin
          state_nxt = (eff_cols == '0) ? S_IDLE : S_PIX;
        end
      end
      S_PIX: begin
        if (gen_go && col_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result bit for the current state
  logic gen_chain, gen_bit, gen_latch, gen_last;

  always_comb begin
    gen_chain = CHAIN_COL;
    gen_bit   = 1'b0;
    gen_latch = 1'b0;
    gen_last  = 1'b0;
    unique case (state_r)
      S_IDLE: ;
      S_ZERO: begin
        gen_latch = col_end;
      end
      S_TOKEN: begin
        gen_chain = CHAIN_ROW;
        gen_bit   = row_zero_r;
        gen_latch = 1'b1;
        gen_last  = (eff_cols == '0);
      end
      S_PIX: begin
        gen_bit   = row_sh_r[0];
        gen_latch = col_end;
        gen_last  = col_end;
      end
      default: ;
    endcase
  end

  // output register
  logic out_chain_r, out_bit_r, out_latch_r, out_last_r;

  always_comb begin
    if (gen_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_go) begin
      out_chain_r <= gen_chain;
      out_bit_r   <= gen_bit;
      out_latch_r <= gen_latch;
      out_last_r  <= gen_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chain       = out_chain_r;
  assign out_bit_out     = out_bit_r;
  assign out_latch_after = out_latch_r;
  assign out_last        = out_last_r;

  // checks
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(scan_row_r) < MAX_ROWS)
    else $error("scan row beyond store depth");

  a_adv_starts: assert property (@(posedge clk) disable iff (!rst_n)
    adv_fire |=> (state_r != S_IDLE))
    else $error("advance item did not start a run");

  a_last_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_latch_after)
    else $error("final bit without latch");

  a_token_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_chain == CHAIN_ROW)) |-> out_latch_after)
    else $error("row token without latch");

endmodule
